// File: rtl/core/tinted_layer_additive_compositor_assert.svh
// ----------------------------------------------------------------------------
// Tinted layer compositor assertion macros
// Shared wrappers for concurrent checks, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TINTED_LAYER_ADDITIVE_COMPOSITOR_ASSERT_SVH
`define TINTED_LAYER_ADDITIVE_COMPOSITOR_ASSERT_SVH

// Same-cycle implication.
`define TLAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TLAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/tlac_pkg.sv
// ----------------------------------------------------------------------------
// Tinted layer compositor package
// Shared pixel type, widths and the exact divide-by-255 helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlac_pkg;

    localparam int MAX_LAYERS      = 4;
    localparam int NUM_LAYERS_DEF  = 4;
    localparam int CHAN_W          = 8;
    localparam int TINT_W          = 3 * CHAN_W;
    localparam int CFG_INDEX_W     = 3;
    localparam int PROD_W          = 2 * CHAN_W;
    localparam int SUM_W           = CHAN_W + $clog2(MAX_LAYERS + 1);
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    typedef logic [CHAN_W-1:0] level_t;

    // Exact floor(p / 255) for every product of two channel values (p up to 65025):
    // (p + 1 + (p >> 8)) >> 8.
    function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
        logic [PROD_W:0] s;
        s = {1'b0, p} + (PROD_W+1)'(1) + (PROD_W+1)'(p[PROD_W-1:CHAN_W]);
        return s[PROD_W-1:CHAN_W];
    endfunction

endpackage

// File: rtl/core/tlac_cfg_regs.sv
// ----------------------------------------------------------------------------
// Tinted layer compositor tint registers
// Holds one RGB888 tint per active layer, written over the register channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlac_cfg_regs #(
    parameter int NUM_LAYERS = tlac_pkg::NUM_LAYERS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tlac_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tlac_pkg::TINT_W-1:0]        cfg_data,
    output tlac_pkg::rgb_t                     tint [NUM_LAYERS]
);

    tlac_pkg::rgb_t tint_reg [NUM_LAYERS];
    logic           wr_en;

    // Writes are always taken; indexes with no register behind them are dropped.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid && cfg_ready;

    for (genvar l = 0; l < NUM_LAYERS; l++) begin : g_tint
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tint_reg[l] <= '0;
            end
            else if (wr_en && (cfg_index == tlac_pkg::CFG_INDEX_W'(l)))
            begin
                tint_reg[l] <= tlac_pkg::rgb_t'(cfg_data);
            end
        end
        assign tint[l] = tint_reg[l];
    end

endmodule

// File: rtl/core/tlac_pipe.sv
// ----------------------------------------------------------------------------
// Tinted layer compositor datapath
// Three-stage pipeline: tint products, divide by 255, sum and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlac_pipe #(
    parameter int NUM_LAYERS = tlac_pkg::NUM_LAYERS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  tlac_pkg::rgb_t       bg,
    input  tlac_pkg::level_t     level [tlac_pkg::MAX_LAYERS],
    input  tlac_pkg::rgb_t       tint  [NUM_LAYERS],
    output logic                 out_valid,
    input  logic                 out_stall,
    output tlac_pkg::rgb_t       result
);

`include "tinted_layer_additive_compositor_assert.svh"

    typedef struct packed {
        logic [tlac_pkg::PROD_W-1:0] red;
        logic [tlac_pkg::PROD_W-1:0] green;
        logic [tlac_pkg::PROD_W-1:0] blue;
    } prod_t;

    // Stage valid bits and per-stage load enables.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic en1, en2, en3;

    prod_t          prod_reg [NUM_LAYERS];
    tlac_pkg::rgb_t bg1_reg;
    tlac_pkg::rgb_t quot_reg [NUM_LAYERS];
    tlac_pkg::rgb_t bg2_reg;
    tlac_pkg::rgb_t res_reg, res_next;

    // A stage loads when it is empty or its content moves on this edge.
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_stall = !en1;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage 1: tint channel times level for every layer.
    for (genvar l = 0; l < NUM_LAYERS; l++) begin : g_layer
        always_ff @(posedge clk)
        begin
            if (en1)
            begin
                prod_reg[l].red   <= tlac_pkg::PROD_W'(tint[l].red)   *
                                     tlac_pkg::PROD_W'(level[l]);
                prod_reg[l].green <= tlac_pkg::PROD_W'(tint[l].green) *
                                     tlac_pkg::PROD_W'(level[l]);
                prod_reg[l].blue  <= tlac_pkg::PROD_W'(tint[l].blue)  *
                                     tlac_pkg::PROD_W'(level[l]);
            end
        end

        // Stage 2: truncating division by 255.
        always_ff @(posedge clk)
        begin
            if (en2)
            begin
                quot_reg[l].red   <= tlac_pkg::div255(prod_reg[l].red);
                quot_reg[l].green <= tlac_pkg::div255(prod_reg[l].green);
                quot_reg[l].blue  <= tlac_pkg::div255(prod_reg[l].blue);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            bg1_reg <= bg;
        end
        if (en2)
        begin
            bg2_reg <= bg1_reg;
        end
        if (en3)
        begin
            res_reg <= res_next;
        end
    end

    // Stage 3: add all layer terms onto the background and clamp.
    always_comb
    begin
        logic [tlac_pkg::SUM_W-1:0] acc_r;
        logic [tlac_pkg::SUM_W-1:0] acc_g;
        logic [tlac_pkg::SUM_W-1:0] acc_b;
        acc_r = tlac_pkg::SUM_W'(bg2_reg.red);
        acc_g = tlac_pkg::SUM_W'(bg2_reg.green);
        acc_b = tlac_pkg::SUM_W'(bg2_reg.blue);
        for (int l = 0; l < NUM_LAYERS; l++)
        begin
            acc_r = acc_r + tlac_pkg::SUM_W'(quot_reg[l].red);
            acc_g = acc_g + tlac_pkg::SUM_W'(quot_reg[l].green);
            acc_b = acc_b + tlac_pkg::SUM_W'(quot_reg[l].blue);
        end
        res_next.red   = (acc_r > tlac_pkg::SUM_W'(tlac_pkg::CHAN_MAX)) ?
                         tlac_pkg::CHAN_MAX : acc_r[tlac_pkg::CHAN_W-1:0];
        res_next.green = (acc_g > tlac_pkg::SUM_W'(tlac_pkg::CHAN_MAX)) ?
                         tlac_pkg::CHAN_MAX : acc_g[tlac_pkg::CHAN_W-1:0];
        res_next.blue  = (acc_b > tlac_pkg::SUM_W'(tlac_pkg::CHAN_MAX)) ?
                         tlac_pkg::CHAN_MAX : acc_b[tlac_pkg::CHAN_W-1:0];
    end

    assign out_valid = v3_reg;
    assign result    = res_reg;

    `TLAC_ASSERT_SAME(a_stall_only_when_full, in_stall,
        v1_reg && v2_reg && v3_reg && out_stall, "input stalled with a free stage")
    `TLAC_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall,
        v1_reg, "accepted transaction did not reach stage 1")
    `TLAC_ASSERT_NEXT(a_s1_holds, v1_reg && !en2,
        v1_reg && $stable(bg1_reg), "blocked stage 1 lost its transaction")
    `TLAC_ASSERT_NEXT(a_drain, v3_reg && !out_stall && !v2_reg,
        !v3_reg, "result repeated after it was taken")

endmodule

// File: rtl/core/tinted_layer_additive_compositor.sv
// ----------------------------------------------------------------------------
// Tinted layer additive compositor
// Adds up to four tinted luminance layers onto an RGB888 pixel, saturating.
//
// Input channel: in_valid / in_stall carry one pixel per transaction, the
// background bg_red/bg_green/bg_blue and one 8-bit level per mask layer.
// Output channel: out_valid / out_stall carry out_red/out_green/out_blue.
// Register channel: cfg_valid / cfg_ready with cfg_index and cfg_data write
// the RGB888 tints, index 0 to 3 for layers 0 to 3; other indexes are
// ignored. cfg_ready is always high. Write tints only while the block is idle.
// An accepted pixel reaches the port through the multiply, divide-by-255 and
// sum/saturate register stages. Throughput is one pixel per cycle while the
// output is not stalled. A stall on the output freezes the last stage;
// earlier stages keep filling bubbles, and in_stall rises only when all
// three stages are full, so nothing is lost or repeated.
// Reset empties the pipeline and clears every tint to zero (black).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tinted_layer_additive_compositor #(
    parameter int NUM_LAYERS = tlac_pkg::NUM_LAYERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tlac_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tlac_pkg::TINT_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tlac_pkg::CHAN_W-1:0]       bg_red,
    input  logic [tlac_pkg::CHAN_W-1:0]       bg_green,
    input  logic [tlac_pkg::CHAN_W-1:0]       bg_blue,
    input  logic [tlac_pkg::CHAN_W-1:0]       layer0_level,
    input  logic [tlac_pkg::CHAN_W-1:0]       layer1_level,
    input  logic [tlac_pkg::CHAN_W-1:0]       layer2_level,
    input  logic [tlac_pkg::CHAN_W-1:0]       layer3_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tlac_pkg::CHAN_W-1:0]       out_red,
    output logic [tlac_pkg::CHAN_W-1:0]       out_green,
    output logic [tlac_pkg::CHAN_W-1:0]       out_blue
);

    tlac_pkg::rgb_t   tint [NUM_LAYERS];
    tlac_pkg::rgb_t   bg;
    tlac_pkg::rgb_t   result;
    tlac_pkg::level_t level [tlac_pkg::MAX_LAYERS];

    assign bg.red   = bg_red;
    assign bg.green = bg_green;
    assign bg.blue  = bg_blue;

    assign level[0] = layer0_level;
    assign level[1] = layer1_level;
    assign level[2] = layer2_level;
    assign level[3] = layer3_level;

    tlac_cfg_regs #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tint      (tint)
    );

    tlac_pipe #(
        .NUM_LAYERS (NUM_LAYERS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bg        (bg),
        .level     (level),
        .tint      (tint),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    assign out_red   = result.red;
    assign out_green = result.green;
    assign out_blue  = result.blue;

endmodule

// File: dv/tinted_layer_additive_compositor_test.sv
// ----------------------------------------------------------------------------
// Tinted layer compositor testbench
// Programs the four layer tints through several settings, drives directed and
// random pixels in bursts against a stalling receiver, and compares every
// composited pixel with a locally computed saturating sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tinted_layer_additive_compositor_test;

    localparam int ACTIVE_LAYERS   = tlac_pkg::NUM_LAYERS_DEF;
    localparam int TINT_SEL_W      = $clog2(tlac_pkg::MAX_LAYERS);
    localparam int IDLE_LIMIT      = 4000;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_PIXELS    = 250;
    localparam int MISMATCH_REPORT = 10;

    typedef struct packed {
        tlac_pkg::rgb_t                                bg;
        tlac_pkg::level_t [tlac_pkg::MAX_LAYERS-1:0]   level;
    } pixel_t;

    typedef logic [tlac_pkg::MAX_LAYERS-1:0][tlac_pkg::TINT_W-1:0] tint_set_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    // Holds the current tints and the composited pixels still owed by the block.
    class tinted_pixel_tracker;
        int                          layers;
        logic [tlac_pkg::TINT_W-1:0] tint [tlac_pkg::MAX_LAYERS];
        tlac_pkg::rgb_t              awaited_pixels [$];
        int                          mismatch_count;

        function new(int active_layers);
            layers = active_layers;
            mismatch_count = 0;
            foreach (tint[i])
                tint[i] = '0;
        endfunction

        function void note_tint(logic [tlac_pkg::CFG_INDEX_W-1:0] index,
                                logic [tlac_pkg::TINT_W-1:0] data);
            if (index < tlac_pkg::CFG_INDEX_W'(tlac_pkg::MAX_LAYERS))
                tint[index[TINT_SEL_W-1:0]] = data;
        endfunction

        function tlac_pkg::rgb_t blend_pixel(pixel_t p);
            int unsigned    sum_r;
            int unsigned    sum_g;
            int unsigned    sum_b;
            tlac_pkg::rgb_t res;
            sum_r = p.bg.red;
            sum_g = p.bg.green;
            sum_b = p.bg.blue;
            for (int i = 0; i < layers && i < tlac_pkg::MAX_LAYERS; i++)
            begin
                sum_r += (int'(tint[i][23:16]) * int'(p.level[i])) / 255;
                sum_g += (int'(tint[i][15:8]) * int'(p.level[i])) / 255;
                sum_b += (int'(tint[i][7:0]) * int'(p.level[i])) / 255;
            end
            res.red   = (sum_r > 255) ? tlac_pkg::CHAN_MAX : 8'(sum_r);
            res.green = (sum_g > 255) ? tlac_pkg::CHAN_MAX : 8'(sum_g);
            res.blue  = (sum_b > 255) ? tlac_pkg::CHAN_MAX : 8'(sum_b);
            return res;
        endfunction

        function void note_pixel(pixel_t p);
            awaited_pixels.push_back(blend_pixel(p));
        endfunction

        function void check_pixel(tlac_pkg::rgb_t got);
            tlac_pkg::rgb_t want;
            if (awaited_pixels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_REPORT)
                    $display("%0t: unexpected pixel r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
                return;
            end
            want = awaited_pixels.pop_front();
            if (got.red !== want.red || got.green !== want.green
                || got.blue !== want.blue)
            begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_REPORT)
                    $display({"%0t: pixel mismatch expected r=%0d g=%0d b=%0d",
                              " got r=%0d g=%0d b=%0d"},
                             $realtime, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int pending();
            return awaited_pixels.size();
        endfunction
    endclass

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [tlac_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [tlac_pkg::TINT_W-1:0]       cfg_data = '0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    tlac_pkg::level_t                  bg_red = '0;
    tlac_pkg::level_t                  bg_green = '0;
    tlac_pkg::level_t                  bg_blue = '0;
    tlac_pkg::level_t                  layer0_level = '0;
    tlac_pkg::level_t                  layer1_level = '0;
    tlac_pkg::level_t                  layer2_level = '0;
    tlac_pkg::level_t                  layer3_level = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    tlac_pkg::level_t                  out_red;
    tlac_pkg::level_t                  out_green;
    tlac_pkg::level_t                  out_blue;

    stall_mode_t                       stall_mode = STALL_NONE;
    logic [7:0]                        stall_cycle = '0;
    int                                idle_cycles = 0;

    tinted_pixel_tracker               pixel_tracker = new(ACTIVE_LAYERS);

    tinted_layer_additive_compositor #(
        .NUM_LAYERS (ACTIVE_LAYERS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .bg_red       (bg_red),
        .bg_green     (bg_green),
        .bg_blue      (bg_blue),
        .layer0_level (layer0_level),
        .layer1_level (layer1_level),
        .layer2_level (layer2_level),
        .layer3_level (layer3_level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: checks each accepted pixel and stalls on a mode that is re-chosen
    // at random whenever stall_cycle wraps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                pixel_tracker.check_pixel(tlac_pkg::rgb_t'{red: out_red, green: out_green,
                                                           blue: out_blue});
            stall_cycle <= stall_cycle + 8'd1;
            if (stall_cycle == 8'hFF)
                stall_mode <= stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: out_stall <= (stall_cycle[3:0] >= 4'd11);
                default:        out_stall <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic tlac_pkg::level_t rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return tlac_pkg::level_t'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [tlac_pkg::TINT_W-1:0] rand_tint();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 24'hFFFFFF;
            2:       return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                             8'($urandom_range(0, 3))};
            default: return tlac_pkg::TINT_W'($urandom());
        endcase
    endfunction

    function automatic pixel_t make_pixel(tlac_pkg::level_t r, tlac_pkg::level_t g,
                                          tlac_pkg::level_t b, tlac_pkg::level_t l0,
                                          tlac_pkg::level_t l1, tlac_pkg::level_t l2,
                                          tlac_pkg::level_t l3);
        pixel_t p;
        p.bg.red   = r;
        p.bg.green = g;
        p.bg.blue  = b;
        p.level    = {l3, l2, l1, l0};
        return p;
    endfunction

    // Holds the pixel on the port until the block takes it.
    task automatic send_pixel(pixel_t p);
        in_valid     <= 1'b1;
        bg_red       <= p.bg.red;
        bg_green     <= p.bg.green;
        bg_blue      <= p.bg.blue;
        layer0_level <= p.level[0];
        layer1_level <= p.level[1];
        layer2_level <= p.level[2];
        layer3_level <= p.level[3];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pixel_tracker.note_pixel(p);
    endtask

    // Tints are only rewritten once the pipeline has drained. An ignored
    // register index is optionally written as well.
    task automatic program_tints(tint_set_t tints, bit with_ignored);
        logic [tlac_pkg::CFG_INDEX_W-1:0] idx;
        logic [tlac_pkg::TINT_W-1:0]      data;
        while (pixel_tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        for (int i = 0; i < tlac_pkg::MAX_LAYERS + int'(with_ignored); i++)
        begin
            if (i < tlac_pkg::MAX_LAYERS)
            begin
                idx  = tlac_pkg::CFG_INDEX_W'(i);
                data = tints[i];
            end
            else
            begin
                idx  = tlac_pkg::CFG_INDEX_W'($urandom_range(tlac_pkg::MAX_LAYERS,
                                                   (1 << tlac_pkg::CFG_INDEX_W) - 1));
                data = tlac_pkg::TINT_W'($urandom());
            end
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            pixel_tracker.note_tint(idx, data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_pixels(int count);
        int burst_left;
        burst_left = $urandom_range(1, 40);
        for (int k = 0; k < count; k++)
        begin
            send_pixel(make_pixel(rand_chan(), rand_chan(), rand_chan(),
                                  rand_chan(), rand_chan(), rand_chan(), rand_chan()));
            burst_left--;
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                // Now and then a long burst gives the receiver a steady stream.
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                         : $urandom_range(1, 40);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        tint_set_t tints;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset tints are black, so the background passes straight through.
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'h5A, 8'hA5, 8'h3C, 8'd255, 8'd128, 8'd1, 8'd0));
        in_valid <= 1'b0;

        // White tints on every layer: exact scaling and full saturation.
        tints = {4{24'hFFFFFF}};
        program_tints(tints, 1'b1);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd254, 8'd0));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128));
        send_pixel(make_pixel(8'd200, 8'd100, 8'd0, 8'd55, 8'd0, 8'd0, 8'd1));
        in_valid <= 1'b0;

        // One primary on each of layers 0 to 2 keeps the channels apart; layer 3 mixes all three.
        tints = {24'h7F3F01, 24'h0000FF, 24'h00FF00, 24'hFF0000};
        program_tints(tints, 1'b1);
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255));
        send_pixel(make_pixel(8'd10, 8'd20, 8'd30, 8'd128, 8'd64, 8'd32, 8'd16));
        send_pixel(make_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255));
        send_pixel(make_pixel(8'd254, 8'd254, 8'd254, 8'd3, 8'd3, 8'd3, 8'd3));
        in_valid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            for (int i = 0; i < tlac_pkg::MAX_LAYERS; i++)
                tints[i] = rand_tint();
            if (ph == RANDOM_PHASES - 1)
                tints = '0;
            program_tints(tints, bit'($urandom_range(0, 1)));
            send_random_pixels(PHASE_PIXELS);
        end

        while (pixel_tracker.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (pixel_tracker.mismatch_count == 0 && pixel_tracker.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
